FILE: design/lqrs_pkg.sv
// Types and constants shared by the linear and quadratic root solver.
// Depends on nothing; every other design file takes names from here.
package lqrs_pkg;

    localparam logic [2:0] ST_LINEAR = 3'd0;
    localparam logic [2:0] ST_TWO    = 3'd1;
    localparam logic [2:0] ST_DOUBLE = 3'd2;
    localparam logic [2:0] ST_NONE   = 3'd3;
    localparam logic [2:0] ST_AZERO  = 3'd4;

    localparam int SQ_STEPS = 34;
    localparam int NUM_INT_W = 34;
    localparam int DEN_W = 33;

    typedef struct packed {
        logic               action;
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
    } coef_t;

    typedef struct packed {
        logic signed [31:0] root_first;
        logic signed [31:0] root_second;
        logic [2:0]         root_status;
        logic               saturated;
    } root_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               neg_a;
        logic signed [31:0] b;
        logic [31:0]        a_mag;
    } sq_side_t;

    typedef struct packed {
        logic [2:0] status;
        logic       neg;
    } div_side_t;

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        abs32 = x[31] ? 32'(-x) : 32'(x);
    endfunction

endpackage

FILE: design/lqrs_div.sv
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per stage.
// Depends on lqrs_pkg for the divisor width.
module lqrs_div #(
    parameter int NW = 50,
    parameter int SW = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [NW-1:0]                num,
    input  logic [lqrs_pkg::DEN_W-1:0]   den,
    input  logic [SW-1:0]                side,
    output logic                         out_valid,
    output logic [NW-1:0]                quo,
    output logic [SW-1:0]                out_side
);

    localparam int DW = lqrs_pkg::DEN_W;

    logic          valid_reg [NW+1];
    logic [DW-1:0] rem_reg   [NW+1];
    logic [NW-1:0] nq_reg    [NW+1];
    logic [DW-1:0] den_reg   [NW+1];
    logic [SW-1:0] side_reg  [NW+1];

    assign valid_reg[0] = in_valid;
    assign rem_reg[0]   = '0;
    assign nq_reg[0]    = num;
    assign den_reg[0]   = den;
    assign side_reg[0]  = side;

    genvar i;
    generate
        for (i = 0; i < NW; i++)
        begin : g_step
            logic [DW:0]   rem2;
            logic [DW:0]   diff;
            logic          qbit;
            logic [DW-1:0] rem_next;
            logic [NW-1:0] nq_next;

            always_comb
            begin
                rem2     = {rem_reg[i], nq_reg[i][NW-1]};
                diff     = rem2 - {1'b0, den_reg[i]};
                qbit     = (rem2 >= {1'b0, den_reg[i]});
                rem_next = qbit ? diff[DW-1:0] : rem2[DW-1:0];
                nq_next  = {nq_reg[i][NW-2:0], qbit};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i+1] <= 1'b0;
                end
                else if (adv)
                begin
                    valid_reg[i+1] <= valid_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[i+1]  <= rem_next;
                    nq_reg[i+1]   <= nq_next;
                    den_reg[i+1]  <= den_reg[i];
                    side_reg[i+1] <= side_reg[i];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NW];
    assign quo       = nq_reg[NW];
    assign out_side  = side_reg[NW];

endmodule

FILE: design/linear_quadratic_root_solver.sv
// Solver for a*x+b=0 and a*x^2+b*x+c=0 on signed fixed-point coefficients.
// Depends on lqrs_pkg and lqrs_div.
//
// One coefficient beat is taken every cycle unless the output stalls, and one
// root beat leaves for each, in order. The stages are registered input
// capture, squaring, the discriminant, the one-bit-per-stage square root, the
// numerators, the one-bit-per-stage dividers and clipping into the output
// register. The whole pipeline holds while a finished root beat is stalled.
module linear_quadratic_root_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            coef_valid,
    output logic            coef_stall,
    input  lqrs_pkg::coef_t coef,
    output logic            root_valid,
    input  logic            root_stall,
    output lqrs_pkg::root_t root
);

    localparam int SQ = lqrs_pkg::SQ_STEPS;
    localparam int NMAG_W = lqrs_pkg::NUM_INT_W + FRAC_BITS;
    localparam int DW = lqrs_pkg::DEN_W;

    logic adv;
    logic root_valid_reg;
    lqrs_pkg::root_t root_reg;

    assign adv        = !(root_valid_reg && root_stall);
    assign coef_stall = !adv;

    // input capture
    logic            s0_valid_reg;
    lqrs_pkg::coef_t s0_reg;

    // squares and side data
    logic               s1_valid_reg;
    logic [63:0]        p_reg;
    logic [63:0]        m_reg;
    logic               prod_neg_reg;
    lqrs_pkg::sq_side_t s1_side_reg;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
    logic [31:0]        abs_c;
    lqrs_pkg::sq_side_t s1_side_next;

    // discriminant and square root stages
    logic               sq_valid_reg [SQ+1];
    logic [35:0]        sq_rem_reg   [SQ+1];
    logic [33:0]        sq_root_reg  [SQ+1];
    logic [67:0]        sq_d_reg     [SQ+1];
    lqrs_pkg::sq_side_t sq_side_reg  [SQ+1];
    logic [65:0]        q4;
    logic [65:0]        p66;
    logic [65:0]        d_next;
    lqrs_pkg::sq_side_t s2_side_next;

    always_comb
    begin
        abs_a = lqrs_pkg::abs32(s0_reg.coef_a);
        abs_b = lqrs_pkg::abs32(s0_reg.coef_b);
        abs_c = lqrs_pkg::abs32(s0_reg.coef_c);
        s1_side_next.neg_a = s0_reg.coef_a[31];
        s1_side_next.b     = s0_reg.coef_b;
        s1_side_next.a_mag = abs_a;
        if (s0_reg.coef_a == 32'sd0)
        begin
            s1_side_next.status = lqrs_pkg::ST_AZERO;
        end
        else if (!s0_reg.action)
        begin
            s1_side_next.status = lqrs_pkg::ST_LINEAR;
        end
        else
        begin
            s1_side_next.status = lqrs_pkg::ST_TWO;
        end
    end

    always_comb
    begin
        q4           = {m_reg, 2'b00};
        p66          = {2'b00, p_reg};
        s2_side_next = s1_side_reg;
        d_next       = '0;
        if (prod_neg_reg)
        begin
            d_next = p66 + q4;
        end
        else if (q4 <= p66)
        begin
            d_next = p66 - q4;
        end
        else if (s1_side_reg.status == lqrs_pkg::ST_TWO)
        begin
            s2_side_next.status = lqrs_pkg::ST_NONE;
        end
        if (s1_side_reg.status == lqrs_pkg::ST_TWO && d_next == '0
            && (prod_neg_reg || q4 <= p66))
        begin
            s2_side_next.status = lqrs_pkg::ST_DOUBLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg    <= coef_valid;
            s1_valid_reg    <= s0_valid_reg;
            sq_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg         <= coef;
            p_reg          <= abs_b * abs_b;
            m_reg          <= abs_a * abs_c;
            prod_neg_reg   <= s0_reg.coef_a[31] ^ s0_reg.coef_c[31];
            s1_side_reg    <= s1_side_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_d_reg[0]    <= {2'b00, d_next};
            sq_side_reg[0] <= s2_side_next;
        end
    end

    genvar k;
    generate
        for (k = 0; k < SQ; k++)
        begin : g_sqrt
            logic [35:0] rem2;
            logic [35:0] trial;
            logic        take;

            always_comb
            begin
                rem2  = {sq_rem_reg[k][33:0], sq_d_reg[k][67:66]};
                trial = {sq_root_reg[k], 2'b01};
                take  = (rem2 >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_valid_reg[k+1] <= 1'b0;
                end
                else if (adv)
                begin
                    sq_valid_reg[k+1] <= sq_valid_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_rem_reg[k+1]  <= take ? (rem2 - trial) : rem2;
                    sq_root_reg[k+1] <= {sq_root_reg[k][32:0], take};
                    sq_d_reg[k+1]    <= {sq_d_reg[k][65:0], 2'b00};
                    sq_side_reg[k+1] <= sq_side_reg[k];
                end
            end
        end
    endgenerate

    // numerators and divisor
    lqrs_pkg::sq_side_t nside;
    logic [33:0]        s_sel;
    logic signed [35:0] n1;
    logic signed [35:0] n2;
    logic [35:0]        n1_mag;
    logic [35:0]        n2_mag;
    logic               nv_valid_reg;
    logic [NMAG_W-1:0]  n1_reg;
    logic [NMAG_W-1:0]  n2_reg;
    logic [DW-1:0]      den_reg;
    lqrs_pkg::div_side_t dside1_reg;
    logic               neg2_reg;

    always_comb
    begin
        nside  = sq_side_reg[SQ];
        s_sel  = (nside.status == lqrs_pkg::ST_TWO) ? sq_root_reg[SQ] : '0;
        n1     = -36'(nside.b) - $signed({2'b00, s_sel});
        n2     = -36'(nside.b) + $signed({2'b00, s_sel});
        n1_mag = n1[35] ? 36'(-n1) : 36'(n1);
        n2_mag = n2[35] ? 36'(-n2) : 36'(n2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            nv_valid_reg <= sq_valid_reg[SQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_reg <= {n1_mag[33:0], {FRAC_BITS{1'b0}}};
            n2_reg <= {n2_mag[33:0], {FRAC_BITS{1'b0}}};
            if (nside.status == lqrs_pkg::ST_LINEAR)
            begin
                den_reg <= {1'b0, nside.a_mag};
            end
            else
            begin
                den_reg <= {nside.a_mag, 1'b0};
            end
            dside1_reg.status <= nside.status;
            dside1_reg.neg    <= n1[35] ^ nside.neg_a;
            neg2_reg          <= n2[35] ^ nside.neg_a;
        end
    end

    logic                div1_valid;
    logic                div2_valid;
    logic [NMAG_W-1:0]   q1;
    logic [NMAG_W-1:0]   q2;
    lqrs_pkg::div_side_t dside1_out;
    logic                neg2_out;

    lqrs_div #(.NW(NMAG_W), .SW(4)) u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (nv_valid_reg),
        .num      (n1_reg),
        .den      (den_reg),
        .side     (dside1_reg),
        .out_valid(div1_valid),
        .quo      (q1),
        .out_side (dside1_out)
    );

    lqrs_div #(.NW(NMAG_W), .SW(1)) u_div2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (nv_valid_reg),
        .num      (n2_reg),
        .den      (den_reg),
        .side     (neg2_reg),
        .out_valid(div2_valid),
        .quo      (q2),
        .out_side (neg2_out)
    );

    // clip into the output register
    logic [31:0]     c1;
    logic [31:0]     c2;
    logic            sat1;
    logic            sat2;
    lqrs_pkg::root_t root_next;

    always_comb
    begin
        if (dside1_out.neg)
        begin
            sat1 = (|q1[NMAG_W-1:32]) || (q1[31] && (|q1[30:0]));
            c1   = sat1 ? 32'h8000_0000 : 32'(-q1[31:0]);
        end
        else
        begin
            sat1 = |q1[NMAG_W-1:31];
            c1   = sat1 ? 32'h7FFF_FFFF : q1[31:0];
        end
        if (neg2_out)
        begin
            sat2 = (|q2[NMAG_W-1:32]) || (q2[31] && (|q2[30:0]));
            c2   = sat2 ? 32'h8000_0000 : 32'(-q2[31:0]);
        end
        else
        begin
            sat2 = |q2[NMAG_W-1:31];
            c2   = sat2 ? 32'h7FFF_FFFF : q2[31:0];
        end
        root_next.root_status = dside1_out.status;
        root_next.root_first  = '0;
        root_next.root_second = '0;
        root_next.saturated   = 1'b0;
        case (dside1_out.status)
            lqrs_pkg::ST_LINEAR:
            begin
                root_next.root_first = $signed(c1);
                root_next.saturated  = sat1;
            end
            lqrs_pkg::ST_TWO, lqrs_pkg::ST_DOUBLE:
            begin
                root_next.root_first  = $signed(c1);
                root_next.root_second = $signed(c2);
                root_next.saturated   = sat1 | sat2;
            end
            default:
            begin
                root_next.saturated = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            root_valid_reg <= div1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            root_reg <= root_next;
        end
    end

    assign root_valid = root_valid_reg;
    assign root       = root_reg;

`ifndef SYNTHESIS
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div1_valid == div2_valid)
        else $error("dividers out of step");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid |-> root.root_status <= lqrs_pkg::ST_AZERO)
        else $error("root status out of range");

    a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && (root.root_status == lqrs_pkg::ST_NONE
                       || root.root_status == lqrs_pkg::ST_AZERO)
        |-> root.root_first == 32'sd0 && root.root_second == 32'sd0
            && !root.saturated)
        else $error("roots reported where none exist");

    a_double_equal: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root.root_status == lqrs_pkg::ST_DOUBLE
        |-> root.root_first == root.root_second)
        else $error("double root halves differ");
`endif

endmodule

FILE: bench/tb_linear_quadratic_root_solver.sv
// Testbench for linear_quadratic_root_solver: directed and random coefficient beats,
// each result checked against a bit-accurate predictor. Depends on lqrs_pkg and the DUT.
`timescale 1ns / 100ps

module tb_linear_quadratic_root_solver;

    localparam int FRAC = 16;
    localparam int LATENCY = 73 + FRAC;
    localparam longint CYCLE_LIMIT = 400000;

    logic            clk;
    logic            rst_n;
    logic            coef_valid;
    logic            coef_stall;
    lqrs_pkg::coef_t coef;
    logic            root_valid;
    logic            root_stall;
    lqrs_pkg::root_t root;

    lqrs_pkg::root_t roots_due[$];
    int              errors;
    int              beats_sent;
    int              beats_checked;
    longint          cycles;

    linear_quadratic_root_solver #(.FRAC_BITS(FRAC)) DUT (
        .clk(clk), .rst_n(rst_n), .coef_valid(coef_valid), .coef_stall(coef_stall),
        .coef(coef), .root_valid(root_valid), .root_stall(root_stall), .root(root)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic signed [31:0] clip_root(input logic signed [127:0] v,
                                                     inout logic sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [127:0] floor_sqrt(input logic [127:0] d);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int i = 33; i >= 0; i--)
        begin
            t = r | (128'd1 << i);
            if (t * t <= d)
                r = t;
        end
        return r;
    endfunction

    function automatic lqrs_pkg::root_t solve_roots(input lqrs_pkg::coef_t c);
        lqrs_pkg::root_t r;
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] k;
        logic signed [127:0] d;
        logic signed [127:0] s;
        logic sat;
        a = c.coef_a;
        b = c.coef_b;
        k = c.coef_c;
        sat = 1'b0;
        r = '0;
        if (a == 0)
            r.root_status = lqrs_pkg::ST_AZERO;
        else if (!c.action)
        begin
            r.root_first = clip_root((-b * (128'sd1 <<< FRAC)) / a, sat);
            r.root_status = lqrs_pkg::ST_LINEAR;
        end
        else
        begin
            d = b * b - 4 * a * k;
            if (d < 0)
                r.root_status = lqrs_pkg::ST_NONE;
            else if (d == 0)
            begin
                r.root_first = clip_root((-b * (128'sd1 <<< FRAC)) / (2 * a), sat);
                r.root_second = r.root_first;
                r.root_status = lqrs_pkg::ST_DOUBLE;
            end
            else
            begin
                s = $signed(floor_sqrt(d));
                r.root_first = clip_root(((-b - s) * (128'sd1 <<< FRAC)) / (2 * a), sat);
                r.root_second = clip_root(((-b + s) * (128'sd1 <<< FRAC)) / (2 * a), sat);
                r.root_status = lqrs_pkg::ST_TWO;
            end
        end
        r.saturated = sat;
        return r;
    endfunction

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 90);
    endfunction

    task automatic send_coef(input lqrs_pkg::coef_t c);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            coef_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        coef_valid <= 1'b1;
        coef <= c;
        @(posedge clk);
        while (coef_stall)
            @(posedge clk);
        roots_due.push_back(solve_roots(c));
        beats_sent++;
    endtask

    task automatic send_quad(input logic signed [31:0] a, input logic signed [31:0] b,
                             input logic signed [31:0] k);
        lqrs_pkg::coef_t c;
        c.action = 1'b1;
        c.coef_a = a;
        c.coef_b = b;
        c.coef_c = k;
        send_coef(c);
    endtask

    task automatic send_lin(input logic signed [31:0] a, input logic signed [31:0] b);
        lqrs_pkg::coef_t c;
        c.action = 1'b0;
        c.coef_a = a;
        c.coef_b = b;
        c.coef_c = $urandom;
        send_coef(c);
    endtask

    task automatic drain_roots();
        coef_valid <= 1'b0;
        @(posedge clk);
        while (roots_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            3: return $signed(32'($urandom_range(1, 40)) << 16) *
                      ($urandom_range(0, 1) ? -1 : 1);
            4: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 9)) - 5;
        endcase
    endfunction

    task automatic test_directed();
        send_lin(32'sh00010000, 32'sh00020000);
        send_lin(32'sh00000000, 32'sh00050000);
        send_quad(32'sh00000000, 32'sh00010000, 32'sh00010000);
        send_lin(32'sh00000001, 32'sh7FFFFFFF);
        send_lin(32'sh00000001, 32'sh80000000);
        send_lin(32'sh80000000, 32'sh80000000);
        send_lin(32'sh7FFFFFFF, 32'shFFFFFFFF);
        send_lin(32'shFFFFFFFF, 32'sh00000000);
        send_quad(32'sh00010000, 32'shFFFD0000, 32'sh00020000);
        send_quad(32'sh00010000, 32'sh00020000, 32'sh00010000);
        send_quad(32'sh00010000, 32'sh00000000, 32'sh00010000);
        send_quad(32'sh00000001, 32'sh7FFFFFFF, 32'sh00000000);
        send_quad(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_quad(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_quad(32'sh80000000, 32'sh00000000, 32'sh7FFFFFFF);
        send_quad(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
        send_quad(32'shFFFFFFFF, 32'sh00000000, 32'sh00000000);
        send_quad(32'sh00000001, 32'sh00000002, 32'sh00000001);
        send_quad(32'sh00000002, 32'sh00000000, 32'shFFFFFFFE);
        send_quad(32'shFFFF0000, 32'sh00000000, 32'sh00000000);
    endtask

    task automatic test_hold_off();
        drain_roots();
        send_quad(32'sh00010000, 32'sh00000000, 32'shFFFC0000);
    endtask

    task automatic test_random(input int n);
        lqrs_pkg::coef_t c;
        logic signed [31:0] p;
        logic signed [31:0] q;
        for (int i = 0; i < n; i++)
        begin
            c.action = $urandom_range(0, 1);
            c.coef_a = ($urandom_range(0, 30) == 0) ? 32'sd0 : rand_coef();
            c.coef_b = rand_coef();
            c.coef_c = rand_coef();
            if (c.action && $urandom_range(0, 5) == 0)
            begin
                p = $signed($urandom_range(0, 200)) - 100;
                q = $signed($urandom_range(0, 200)) - 100;
                c.coef_a = 32'sh10000;
                c.coef_b = -(p + q) <<< 16;
                c.coef_c = (p * q) <<< 16;
                if ($urandom_range(0, 1))
                    c.coef_b = -(2 * p) <<< 16;
                if (c.coef_b == -(2 * p) <<< 16)
                    c.coef_c = (p * p) <<< 16;
            end
            send_coef(c);
        end
    endtask

    initial
    begin
        root_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 299) == 0)
            begin
                root_stall <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
                root_stall <= 1'b1;
            else
                root_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        lqrs_pkg::root_t want;
        if (rst_n && root_valid && !root_stall)
        begin
            if (roots_due.size() == 0)
            begin
                $display("%0t unexpected root beat %h", $time, root);
                errors++;
            end
            else
            begin
                want = roots_due.pop_front();
                beats_checked++;
                if (root.root_first !== want.root_first)
                begin
                    $display("%0t root_first expected %h actual %h", $time,
                             want.root_first, root.root_first);
                    errors++;
                end
                if (root.root_second !== want.root_second)
                begin
                    $display("%0t root_second expected %h actual %h", $time,
                             want.root_second, root.root_second);
                    errors++;
                end
                if (root.root_status !== want.root_status)
                begin
                    $display("%0t root_status expected %0d actual %0d", $time,
                             want.root_status, root.root_status);
                    errors++;
                end
                if (root.saturated !== want.saturated)
                begin
                    $display("%0t saturated expected %b actual %b", $time,
                             want.saturated, root.saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0;
        beats_sent = 0;
        beats_checked = 0;
        coef_valid = 1'b0;
        coef = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_hold_off();
        test_random(1500);
        drain_roots();
        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d coefficient beats, checked %0d root beats", beats_sent,
                 beats_checked);
        $display("covered linear, two-root, double, complex, zero-a and clipped cases");
        if (errors == 0 && roots_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
